// ===== rtl/core/mmf_pkg.sv =====
// ----------------------------------------------------------------------------
// mmf_pkg: shared types and constants for the 3x3 median / mean filter
// pixel type, action codes, register indexes and window helper functions
// ----------------------------------------------------------------------------
package mmf_pkg;

  typedef logic [23:0] pix_t;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // sort three values: returns {max, med, min}
  function automatic logic [23:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    logic [7:0] lo, hi, md;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) begin
      md = lo; lo = c;
    end else if (c > hi) begin
      md = hi; hi = c;
    end else begin
      md = c;
    end
    return {hi, md, lo};
  endfunction

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [23:0] s;
    s = sort3(a, b, c);
    return s[15:8];
  endfunction

endpackage

// ===== rtl/core/mmf_cell.sv =====
// ----------------------------------------------------------------------------
// mmf_cell: one window column cell
// holds the top, middle and bottom pixel of one column, shifts to its left neighbor
// ----------------------------------------------------------------------------
module mmf_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  mmf_pkg::pix_t top_in,
  input  mmf_pkg::pix_t mid_in,
  input  mmf_pkg::pix_t bot_in,
  output mmf_pkg::pix_t top_out,
  output mmf_pkg::pix_t mid_out,
  output mmf_pkg::pix_t bot_out
);
  import mmf_pkg::*;

  pix_t top, mid, bot;

  // column register, shifted on each taken request
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
      mid <= '0;
      bot <= '0;
    end else if (en) begin
      top <= top_in;
      mid <= mid_in;
      bot <= bot_in;
    end
  end

  assign top_out = top;
  assign mid_out = mid;
  assign bot_out = bot;

endmodule

// ===== rtl/core/mmf_calc.sv =====
// ----------------------------------------------------------------------------
// mmf_calc: window reduction stages
// stage 1 sorts columns and sums, stage 2 median network and divide by nine
// ----------------------------------------------------------------------------
module mmf_calc (
  input  logic         clk,
  input  logic         en1,
  input  logic         en2,
  input  mmf_pkg::pix_t w0, w1, w2, w3, w4, w5, w6, w7, w8,
  output logic [23:0]  med,
  output logic [23:0]  avg
);
  import mmf_pkg::*;

  logic [23:0] s0 [3], s1 [3], s2 [3];
  logic [11:0] sum [3];

  // stage 1: sort each column per channel and add the nine values
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 3; k++) begin
        s0[k]  <= sort3(w0[8*k +: 8], w3[8*k +: 8], w6[8*k +: 8]);
        s1[k]  <= sort3(w1[8*k +: 8], w4[8*k +: 8], w7[8*k +: 8]);
        s2[k]  <= sort3(w2[8*k +: 8], w5[8*k +: 8], w8[8*k +: 8]);
        sum[k] <= 12'(w0[8*k +: 8]) + 12'(w1[8*k +: 8]) + 12'(w2[8*k +: 8])
                + 12'(w3[8*k +: 8]) + 12'(w4[8*k +: 8]) + 12'(w5[8*k +: 8])
                + 12'(w6[8*k +: 8]) + 12'(w7[8*k +: 8]) + 12'(w8[8*k +: 8]);
      end
    end
  end

  // stage 2: median = med(max of mins, med of meds, min of maxes); sum*7282 >> 16 = /9
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < 3; k++) begin
        med[8*k +: 8] <= med3(max3(s0[k][7:0], s1[k][7:0], s2[k][7:0]),
                              med3(s0[k][15:8], s1[k][15:8], s2[k][15:8]),
                              min3(s0[k][23:16], s1[k][23:16], s2[k][23:16]));
        avg[8*k +: 8] <= 8'((25'(sum[k]) * 25'd7282) >> 16);
      end
    end
  end

endmodule

// ===== rtl/core/median_mean_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// median_mean_filter_3x3: streaming 3x3 median and mean filter, 24-bit BGR
// two line stores, a row of three column cells, two reduction stages
// ----------------------------------------------------------------------------
// channel   dir  handshake         payload
// s_axis    in   tvalid/tready     tdata = pix_b,g,r ; tuser = action
// m_axis    out  tvalid/tready     tdata = median b,g,r, mean b,g,r ; tlast
// cfg       in   cfg_valid/ready   cfg_index, cfg_data
//
// one pixel per clock while the output is free or being taken; a request passes
// the line store read, the window cells and two reduction stages to the output.
// pipeline advances only when its output slot is free or being taken.
// reset clears counters and window; line stores are not cleared.
// ----------------------------------------------------------------------------
module median_mean_filter_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pix_b, pix_g, pix_r
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // median_b,g,r, mean_b,g,r
  output logic        m_axis_tlast,   // last_pixel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import mmf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;

  logic [11:0] image_width;
  logic [15:0] image_height;
  logic [CW-1:0] wdt;
  logic [15:0] hgt;
  // input row runs one past the height during the flush rows
  logic [16:0] in_row;
  logic [15:0] out_row;
  logic [CW-1:0] in_col, out_col;

  // config writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd640;
      image_height <= 16'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[11:0];
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < 12'd3) wdt = CW'(3);
    else if (32'(image_width) > MAX_WIDTH) wdt = CW'(MAX_WIDTH);
    else wdt = CW'(image_width);
    hgt = (image_height < 16'd3) ? 16'd3 : image_height;
  end

  // pipeline valid flags: p0 store read, p1 window, p2 sort/sum, p3 reduce, then output
  logic v0, v1, v2, v3, adv;
  logic l0, l1, l2, l3, i0, i1, i2, i3;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic acc, flushing, take, emit, last, interior;
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign flushing = in_row >= {1'b0, hgt};
  assign take     = acc && (flushing || s_axis_tuser == ACT_PIXEL);
  assign emit     = (in_row >= 17'd2) || (in_row == 17'd1 && in_col != '0);
  assign last     = (out_row >= hgt - 16'd1) && (out_col >= wdt - CW'(1));
  assign interior = out_row >= 16'd1 && out_row <= hgt - 16'd2 &&
                    out_col >= CW'(1) && out_col <= wdt - CW'(2);

  pix_t px;
  assign px = flushing ? '0 : s_axis_tdata;

  // line stores
  pix_t up_mem [MAX_WIDTH];
  pix_t md_mem [MAX_WIDTH];
  pix_t top_q, mid_q, px_q;
  logic [AW-1:0] addr, addr_q;
  logic take_q;
  assign addr = in_col[AW-1:0];

  // middle store takes the new pixel, upper store takes the old middle a step later
  always_ff @(posedge clk) begin
    if (take) md_mem[addr] <= px;
    if (adv && take_q) up_mem[addr_q] <= mid_q;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      top_q  <= up_mem[addr];
      mid_q  <= md_mem[addr];
      px_q   <= px;
      addr_q <= addr;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) take_q <= 1'b0;
    else if (adv) take_q <= take;
  end

  // counters and control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0; in_col <= '0; out_row <= '0; out_col <= '0;
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v0 <= take && emit; v1 <= v0; v2 <= v1; v3 <= v2; m_axis_tvalid <= v3;
      if (take) begin
        if (in_col + CW'(1) >= wdt) begin
          in_col <= '0; in_row <= in_row + 17'd1;
        end else in_col <= in_col + CW'(1);
        if (emit) begin
          if (last) begin
            in_row <= '0; in_col <= '0; out_row <= '0; out_col <= '0;
          end else if (out_col + CW'(1) >= wdt) begin
            out_col <= '0; out_row <= out_row + 16'd1;
          end else out_col <= out_col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l0 <= last; l1 <= l0; l2 <= l1; l3 <= l2;
      i0 <= interior; i1 <= i0; i2 <= i1; i3 <= i2;
    end
  end

  // window cells: col2 newest, col0 oldest
  pix_t t0, m0, b0, t1, m1, b1, t2, m2, b2;
  // the window shifts on every taken request, after its store read is registered
  mmf_cell u_c2 (.clk, .rst, .en(adv && take_q),
    .top_in(top_q), .mid_in(mid_q), .bot_in(px_q),
    .top_out(t2), .mid_out(m2), .bot_out(b2));
  mmf_cell u_c1 (.clk, .rst, .en(adv && take_q),
    .top_in(t2), .mid_in(m2), .bot_in(b2),
    .top_out(t1), .mid_out(m1), .bot_out(b1));
  mmf_cell u_c0 (.clk, .rst, .en(adv && take_q),
    .top_in(t1), .mid_in(m1), .bot_in(b1),
    .top_out(t0), .mid_out(m0), .bot_out(b0));

  logic [23:0] med, avg;
  mmf_calc u_calc (.clk, .en1(adv), .en2(adv),
    .w0(t0), .w1(t1), .w2(t2), .w3(m0), .w4(m1), .w5(m2), .w6(b0), .w7(b1), .w8(b2),
    .med, .avg);

  // window centre is also the pass-through pixel, on column zero too
  pix_t center;
  assign center = m1;
  pix_t o2, o3;
  always_ff @(posedge clk) begin
    if (adv) begin
      o2 <= center;
      o3 <= o2;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tlast <= l3;
      m_axis_tdata <= i3 ? {avg, med} : {o3, o3};
    end
  end

  // checks
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready) else $error("stalled while output empty");
  a_cfg: assert property (@(posedge clk) cfg_ready) else $error("cfg not ready");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 3x3 median / mean filter
// random images of small sizes plus clamped register values, flush
// ticks, stray items, random idling on both streams and one long output hold
// ----------------------------------------------------------------------------
module tb;
  import mmf_pkg::*;

  localparam int STORE_DEPTH = 2048;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 12;

  // scoreboard: running copy of the filter plus the queue of expected outputs
  class filter_scoreboard;
    logic [11:0] width_reg;
    logic [15:0] height_reg;
    pix_t        upper_row [STORE_DEPTH];
    pix_t        middle_row [STORE_DEPTH];
    pix_t        win [9];
    int          in_row, in_col, out_row, out_col;
    logic [48:0] expected_q [$];
    int          mismatches;
    int          results_seen;
    int          interior_seen;
    int          images_done;

    function void clear_state();
      width_reg = 12'd640;
      height_reg = 16'd480;
      foreach (upper_row[i]) upper_row[i] = '0;
      foreach (middle_row[i]) middle_row[i] = '0;
      foreach (win[i]) win[i] = '0;
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
      mismatches = 0;
      results_seen = 0;
      interior_seen = 0;
      images_done = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] value);
      if (idx == REG_WIDTH) width_reg = value[11:0];
      else height_reg = value;
    endfunction

    function int eff_w();
      if (width_reg < 3) return 3;
      if (width_reg > STORE_DEPTH) return STORE_DEPTH;
      return width_reg;
    endfunction

    function int eff_h();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function int clip(int c);
      return (c < STORE_DEPTH) ? c : STORE_DEPTH - 1;
    endfunction

    // middle value of the nine samples of one channel
    function logic [7:0] middle_of_nine(logic [7:0] v [9]);
      logic [7:0] s [9];
      logic [7:0] t;
      int j;
      for (int i = 0; i < 9; i++) begin
        t = v[i];
        j = i;
        while (j > 0 && s[j-1] > t) begin
          s[j] = s[j-1];
          j--;
        end
        s[j] = t;
      end
      return s[4];
    endfunction

    // accepted input request: advance the window and predict any output
    function void note_input(logic act, pix_t data);
      int w, h, r, c, y, x, sum;
      bit flushing, emit, interior, last;
      pix_t px, wrap_px, top, mid, orig;
      logic [7:0] v [9];
      logic [47:0] res;
      w = eff_w();
      h = eff_h();
      flushing = in_row >= h;
      r = in_row;
      c = in_col;
      if (!flushing && act == ACT_FLUSH) return;
      px = flushing ? '0 : data;
      emit = r >= 2 || (r == 1 && c >= 1);
      wrap_px = upper_row[clip(w - 1)];
      top = upper_row[clip(c)];
      mid = middle_row[clip(c)];
      upper_row[clip(c)] = mid;
      middle_row[clip(c)] = px;
      for (int i = 0; i < 3; i++) begin
        win[i*3] = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      if (c + 1 >= w) begin
        in_col = 0;
        in_row = r + 1;
      end else begin
        in_col = c + 1;
      end
      if (!emit) return;
      y = out_row;
      x = out_col;
      interior = y >= 1 && y <= h - 2 && x >= 1 && x <= w - 2;
      orig = (c == 0) ? wrap_px : win[4];
      for (int k = 0; k < 3; k++) begin
        if (interior) begin
          sum = 0;
          for (int i = 0; i < 9; i++) begin
            v[i] = win[i][8*k +: 8];
            sum += v[i];
          end
          res[8*k +: 8] = middle_of_nine(v);
          res[24 + 8*k +: 8] = 8'(sum / 9);
        end else begin
          res[8*k +: 8] = orig[8*k +: 8];
          res[24 + 8*k +: 8] = orig[8*k +: 8];
        end
      end
      if (interior) interior_seen++;
      last = y >= h - 1 && x >= w - 1;
      expected_q.push_back({last, res});
      if (last) begin
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        foreach (win[i]) win[i] = '0;
        images_done++;
      end else if (x + 1 >= w) begin
        out_col = 0;
        out_row = y + 1;
      end else begin
        out_col = x + 1;
      end
    endfunction

    // accepted output request: compare with the oldest prediction
    function void check_result(logic [47:0] data, logic last);
      logic [48:0] exp_v;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: data=%h last=%b", data, last);
        return;
      end
      exp_v = expected_q.pop_front();
      for (int f = 0; f < 6; f++) begin
        if (data[8*f +: 8] !== exp_v[8*f +: 8]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output %0d field %0d: expected %h actual %h", results_seen, f,
                     exp_v[8*f +: 8], data[8*f +: 8]);
        end
      end
      if (last !== exp_v[48]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output %0d last: expected %b actual %b", results_seen, exp_v[48],
                   last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // pix_b, pix_g, pix_r
  logic        s_axis_tuser;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // median_b,g,r, mean_b,g,r
  logic        m_axis_tlast;   // last_pixel
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  filter_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int hold_cycles;
  int cycle_count;
  int items_sent;

  median_mean_filter_3x3 dut (.*);

  // clock; the single reset is driven from the main initial block
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // input and output monitors
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // receiver: long hold when asked, else random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one input request, with random idle cycles ahead of it
  task automatic send_item(logic act, pix_t px);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= px;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (items_sent % 150 == 0) begin
      case ((items_sent / 150) % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 57;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 57;
        end
        default: begin
          idle_pct = 20;
          stall_pct = 20;
        end
      endcase
    end
  endtask

  // wait until the block is idle, then write one register
  task automatic write_reg(logic idx, logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  // whole image: pixels (mode 0 random, 1 extremes), stray items, then flush ticks
  task automatic run_image(int mode);
    int w, h;
    pix_t px;
    w = sb.eff_w();
    h = sb.eff_h();
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < 3) send_item(ACT_FLUSH, pix_t'($urandom));
      if (mode == 1) px = (i % 2) ? 24'hffffff : 24'h000000;
      else if ($urandom_range(9) == 0) px = $urandom_range(1) ? 24'hffffff : 24'h0;
      else px = pix_t'($urandom);
      if (mode == 1 && i == 4) px = 24'h00ff80;
      send_item(ACT_PIXEL, px);
    end
    for (int i = 0; i <= w; i++)
      send_item($urandom_range(9) == 0 ? ACT_PIXEL : ACT_FLUSH, pix_t'($urandom));
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_PIXEL;
    cfg_valid = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    cycle_count = 0;
    hold_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: smallest image with extreme values, clamped register values
    write_reg(REG_WIDTH, 16'd3);
    write_reg(REG_HEIGHT, 16'd3);
    run_image(1);
    write_reg(REG_WIDTH, 16'd0);
    write_reg(REG_HEIGHT, 16'd1);
    run_image(1);

    // random small images; one of them under a long output hold
    for (int n = 0; n < 30; n++) begin
      write_reg(REG_WIDTH, 16'($urandom_range(12, 1)));
      write_reg(REG_HEIGHT, 16'($urandom_range(8, 2)));
      if (n == 5) hold_cycles = 400;
      run_image(0);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d images, %0d input requests, %0d outputs (%0d interior)",
             sb.images_done, items_sent, sb.results_seen, sb.interior_seen);
    $display("widths 3 to 12 incl. clamped values, heights clamped and random, %0d errors",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
